### src/lqn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lqn_pkg
// Shared types, tables and helpers for the link parameter negotiator.
// ----------------------------------------------------------------------------
package lqn_pkg;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADMSK = 2'd1,
		ST_NOFIT  = 2'd2
	} status_t;

	localparam logic [0:0] REG_BAUD = 1'b0;
	localparam logic [0:0] REG_DISC = 1'b1;

	localparam logic [23:0] BAUD_FLOOR = 24'd115200;
	localparam logic [8:0]  TURN_FORCED_MS = 9'd500;
	localparam logic [3:0]  FRAME_OVERHEAD = 4'd6;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;   // capture a beat and decode the masks
		logic calc;   // register the request for the present window and size
		logic dec_w;  // reduce the window by one
		logic dec_s;  // step the data size down one table entry
		logic nofit;  // mark the result as not fitting
	} lqn_cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic bad;    // empty or out-of-table mask
		logic fits;   // registered request is within capacity
		logic win_gt1;
		logic size_gt0;
	} lqn_sts_t;

	function automatic logic [3:0] top_bit16(input logic [15:0] m);
		logic [3:0] r;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			if (m[i]) r = 4'(i);
		end
		return r;
	endfunction

	function automatic logic [23:0] baud_of(input logic [3:0] i);
		case (i)
			4'd0: return 24'd2400;
			4'd1: return 24'd9600;
			4'd2: return 24'd19200;
			4'd3: return 24'd38400;
			4'd4: return 24'd57600;
			4'd5: return 24'd115200;
			4'd6: return 24'd576000;
			4'd7: return 24'd1152000;
			4'd8: return 24'd4000000;
			4'd9: return 24'd16000000;
			default: return 24'd0;
		endcase
	endfunction

	function automatic logic [11:0] size_of(input logic [2:0] i);
		case (i)
			3'd0: return 12'd64;
			3'd1: return 12'd128;
			3'd2: return 12'd256;
			3'd3: return 12'd512;
			3'd4: return 12'd1024;
			3'd5: return 12'd2048;
			default: return 12'd0;
		endcase
	endfunction

	function automatic logic [5:0] bofs_of(input logic [2:0] i);
		case (i)
			3'd0: return 6'd48;
			3'd1: return 6'd24;
			3'd2: return 6'd12;
			3'd3: return 6'd5;
			3'd4: return 6'd3;
			3'd5: return 6'd2;
			3'd6: return 6'd1;
			default: return 6'd0;
		endcase
	endfunction

	function automatic logic [13:0] minturn_of(input logic [2:0] i);
		case (i)
			3'd0: return 14'd10000;
			3'd1: return 14'd5000;
			3'd2: return 14'd1000;
			3'd3: return 14'd500;
			3'd4: return 14'd100;
			3'd5: return 14'd50;
			3'd6: return 14'd10;
			default: return 14'd0;
		endcase
	endfunction

	function automatic logic [5:0] disc_of(input logic [2:0] i);
		case (i)
			3'd0: return 6'd3;
			3'd1: return 6'd8;
			3'd2: return 6'd12;
			3'd3: return 6'd16;
			3'd4: return 6'd20;
			3'd5: return 6'd25;
			3'd6: return 6'd30;
			default: return 6'd40;
		endcase
	endfunction

	function automatic logic [8:0] maxturn_of(input logic [1:0] i);
		case (i)
			2'd0: return 9'd500;
			2'd1: return 9'd250;
			2'd2: return 9'd100;
			default: return 9'd50;
		endcase
	endfunction

	function automatic logic [19:0] cap_of(input logic [3:0] b, input logic [1:0] t);
		logic [19:0] r;
		r = '0;
		case (b)
			4'd0: r = (t == 2'd0) ? 20'd100 : 20'd0;
			4'd1: r = (t == 2'd0) ? 20'd400 : 20'd0;
			4'd2: r = (t == 2'd0) ? 20'd800 : 20'd0;
			4'd3: r = (t == 2'd0) ? 20'd1600 : 20'd0;
			4'd4: r = (t == 2'd0) ? 20'd2360 : 20'd0;
			4'd5: begin
				case (t)
					2'd0: r = 20'd4800;
					2'd1: r = 20'd2400;
					2'd2: r = 20'd960;
					default: r = 20'd480;
				endcase
			end
			4'd6: begin
				case (t)
					2'd0: r = 20'd28800;
					2'd1: r = 20'd11520;
					2'd2: r = 20'd5760;
					default: r = 20'd2880;
				endcase
			end
			4'd7: begin
				case (t)
					2'd0: r = 20'd57600;
					2'd1: r = 20'd28800;
					2'd2: r = 20'd11520;
					default: r = 20'd5760;
				endcase
			end
			4'd8: begin
				case (t)
					2'd0: r = 20'd200000;
					2'd1: r = 20'd100000;
					2'd2: r = 20'd40000;
					default: r = 20'd20000;
				endcase
			end
			4'd9: begin
				case (t)
					2'd0: r = 20'd800000;
					2'd1: r = 20'd400000;
					2'd2: r = 20'd160000;
					default: r = 20'd80000;
				endcase
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// Min-turn byte term: baud * min_turn_us / 10^7, rounded down, for every
	// table pair. Each row holds the ten baud rates, the fastest on the left.
	function automatic logic [14:0] turn_bytes_of(input logic [3:0] b,
			input logic [2:0] m);
		logic [9:0][14:0] row;
		case (m)
			3'd0: row = {15'd16000, 15'd4000, 15'd1152, 15'd576, 15'd115,
				15'd57, 15'd38, 15'd19, 15'd9, 15'd2};
			3'd1: row = {15'd8000, 15'd2000, 15'd576, 15'd288, 15'd57,
				15'd28, 15'd19, 15'd9, 15'd4, 15'd1};
			3'd2: row = {15'd1600, 15'd400, 15'd115, 15'd57, 15'd11,
				15'd5, 15'd3, 15'd1, 15'd0, 15'd0};
			3'd3: row = {15'd800, 15'd200, 15'd57, 15'd28, 15'd5,
				15'd2, 15'd1, 15'd0, 15'd0, 15'd0};
			3'd4: row = {15'd160, 15'd40, 15'd11, 15'd5, 15'd1,
				15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
			3'd5: row = {15'd80, 15'd20, 15'd5, 15'd2, 15'd0,
				15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
			3'd6: row = {15'd16, 15'd4, 15'd1, 15'd0, 15'd0,
				15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
			default: row = '0;
		endcase
		return (b <= 4'd9) ? row[b] : 15'd0;
	endfunction

endpackage
`default_nettype wire

### src/lqn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lqn_ctrl
// Sequencer for the negotiation: decode, then reduce until the request fits, a mask is bad or no step is left.
// ----------------------------------------------------------------------------
module lqn_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	output lqn_pkg::lqn_cmd_t   cmd,
	input  wire lqn_pkg::lqn_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_CALC, S_TEST, S_DONE
	} state_t;

	state_t state_q;
	logic   take;

	assign in_stall = (state_q != S_IDLE);
	assign take = in_valid && !in_stall;

	// Command decode from the present state. The request register is
	// refreshed after decode of a good mask and in every CALC cycle.
	always_comb begin
		cmd = '0;
		cmd.load = take;
		case (state_q)
			S_CHECK: cmd.calc = !sts.bad;
			S_CALC: cmd.calc = 1'b1;
			S_TEST: begin
				if (!sts.fits) begin
					if (sts.win_gt1) cmd.dec_w = 1'b1;
					else if (sts.size_gt0) cmd.dec_s = 1'b1;
					else cmd.nofit = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// State and the registered valid of the output beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (take) state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.bad) begin
						state_q <= S_DONE;
						out_valid <= 1'b1;
					end else state_q <= S_TEST;
				end
				S_CALC: state_q <= S_TEST;
				S_TEST: begin
					if (sts.fits || (!sts.win_gt1 && !sts.size_gt0)) begin
						state_q <= S_DONE;
						out_valid <= 1'b1;
					end else state_q <= S_CALC;
				end
				S_DONE: begin
					if (!out_stall) begin
						state_q <= S_IDLE;
						out_valid <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

### src/lqn_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lqn_dp
// Datapath: local mask registers, decode, request arithmetic and results.
// ----------------------------------------------------------------------------
module lqn_dp (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic          cfg_index,
	input  wire logic [9:0]    cfg_data,
	input  wire logic          calc_en,
	input  wire lqn_pkg::lqn_cmd_t cmd,
	output lqn_pkg::lqn_sts_t  sts,
	input  wire logic [15:0]   peer_baud_mask,
	input  wire logic [7:0]    peer_disc_mask,
	input  wire logic [7:0]    peer_maxturn_mask,
	input  wire logic [7:0]    peer_datasize_mask,
	input  wire logic [7:0]    peer_window_mask,
	input  wire logic [7:0]    peer_bofs_mask,
	input  wire logic [7:0]    peer_minturn_mask,
	output logic [9:0]         agreed_baud_mask,
	output logic [7:0]         agreed_disc_mask,
	output logic [23:0]        baud_bps,
	output logic [11:0]        frame_bytes,
	output logic [3:0]         window_frames,
	output logic [5:0]         extra_bofs,
	output logic [13:0]        min_turn_us,
	output logic [8:0]         max_turn_ms,
	output logic [5:0]         disc_seconds,
	output logic [1:0]         status
);

	logic [9:0]  loc_baud_q;
	logic [7:0]  loc_disc_q;
	logic [3:0]  ib_q;
	logic [2:0]  is_q;
	logic [3:0]  win_q;
	logic [5:0]  bofs_q;
	logic [14:0] tbytes_q;
	logic [19:0] cap_q;
	logic        bad_q;
	logic [20:0] req_q;
	logic [1:0]  status_q;

	// Local capability registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_baud_q <= 10'h3FF;
			loc_disc_q <= 8'h07;
		end else if (cfg_we) begin
			if (cfg_index == lqn_pkg::REG_BAUD) loc_baud_q <= cfg_data;
			else loc_disc_q <= cfg_data[7:0];
		end
	end

	// Decode of the accepted beat.
	logic [9:0] bm;
	logic [7:0] dm;
	logic [3:0] ib, id, it, is, iw, io, im;
	logic       bad;
	logic [1:0] ti;
	always_comb begin
		bm = peer_baud_mask[9:0] & loc_baud_q;
		dm = peer_disc_mask & loc_disc_q;
		ib = lqn_pkg::top_bit16({6'd0, bm});
		id = lqn_pkg::top_bit16({8'd0, dm});
		it = lqn_pkg::top_bit16({8'd0, peer_maxturn_mask});
		is = lqn_pkg::top_bit16({8'd0, peer_datasize_mask});
		iw = lqn_pkg::top_bit16({8'd0, peer_window_mask});
		io = lqn_pkg::top_bit16({8'd0, peer_bofs_mask});
		im = lqn_pkg::top_bit16({8'd0, peer_minturn_mask});
		bad = (bm == '0) || (dm == '0) || (peer_maxturn_mask == '0) ||
			(peer_datasize_mask == '0) || (peer_window_mask == '0) ||
			(peer_bofs_mask == '0) || (peer_minturn_mask == '0) ||
			(it > 4'd3) || (is > 4'd5);
		ti = it[1:0];
		if (lqn_pkg::baud_of(ib) < lqn_pkg::BAUD_FLOOR) ti = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			agreed_baud_mask <= bm;
			agreed_disc_mask <= dm;
			bad_q <= bad;
			ib_q <= ib;
			is_q <= is[2:0];
			win_q <= iw + 4'd1;
			bofs_q <= lqn_pkg::bofs_of(io[2:0]);
			tbytes_q <= lqn_pkg::turn_bytes_of(ib, im[2:0]);
			cap_q <= lqn_pkg::cap_of(ib, ti);
			baud_bps <= bad ? 24'd0 : lqn_pkg::baud_of(ib);
			min_turn_us <= bad ? 14'd0 : lqn_pkg::minturn_of(im[2:0]);
			max_turn_ms <= bad ? 9'd0 : lqn_pkg::maxturn_of(ti);
			disc_seconds <= bad ? 6'd0 : lqn_pkg::disc_of(id[2:0]);
			extra_bofs <= bad ? 6'd0 : lqn_pkg::bofs_of(io[2:0]);
			status_q <= bad ? lqn_pkg::ST_BADMSK : lqn_pkg::ST_OK;
		end else begin
			if (cmd.dec_w) win_q <= win_q - 4'd1;
			if (cmd.dec_s) is_q <= is_q - 3'd1;
			if (cmd.nofit) status_q <= lqn_pkg::ST_NOFIT;
		end
	end

	// Request: window times per-frame bytes, plus the min-turn bytes.
	logic [12:0] per_frame;
	assign per_frame = 13'(lqn_pkg::size_of(is_q)) + 13'(lqn_pkg::FRAME_OVERHEAD)
		+ 13'(bofs_q);
	always_ff @(posedge clk) begin
		if (calc_en) req_q <= 21'(win_q) * 21'(per_frame) + 21'(tbytes_q);
	end

	assign sts.bad = bad_q;
	assign sts.fits = (req_q <= 21'(cap_q));
	assign sts.win_gt1 = (win_q > 4'd1);
	assign sts.size_gt0 = (is_q != 3'd0);

	assign frame_bytes = bad_q ? 12'd0 : lqn_pkg::size_of(is_q);
	assign window_frames = bad_q ? 4'd0 : win_q;
	assign status = status_q;

endmodule
`default_nettype wire

### src/link_qos_negotiator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// link_qos_negotiator
// Settles link parameters of one connection from decoded peer capability masks.
// ----------------------------------------------------------------------------
// The accepted beat is decoded into registers; in CHECK a bad mask ends the
// item, else the request is registered and tested in TEST. Each window or
// data size reduction step goes through CALC back to TEST; at most 12
// reductions. One beat is in work at a time; the next is taken once the
// result beat is accepted. Reset clears the sequencer and loads the local
// masks with all baud rates and the three shortest disconnect times.
module link_qos_negotiator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [9:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] peer_baud_mask,
	input  wire logic [7:0]  peer_disc_mask,
	input  wire logic [7:0]  peer_maxturn_mask,
	input  wire logic [7:0]  peer_datasize_mask,
	input  wire logic [7:0]  peer_window_mask,
	input  wire logic [7:0]  peer_bofs_mask,
	input  wire logic [7:0]  peer_minturn_mask,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [9:0]       agreed_baud_mask,
	output logic [7:0]       agreed_disc_mask,
	output logic [23:0]      baud_bps,
	output logic [11:0]      frame_bytes,
	output logic [3:0]       window_frames,
	output logic [5:0]       extra_bofs,
	output logic [13:0]      min_turn_us,
	output logic [8:0]       max_turn_ms,
	output logic [5:0]       disc_seconds,
	output logic [1:0]       status
);

	lqn_pkg::lqn_cmd_t cmd;
	lqn_pkg::lqn_sts_t sts;
	logic calc_en;

	// The request is recomputed after decode of a good mask and after each reduction step.
	assign calc_en = cmd.calc;

	lqn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .sts(sts)
	);

	lqn_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.calc_en(calc_en), .cmd(cmd), .sts(sts),
		.peer_baud_mask(peer_baud_mask), .peer_disc_mask(peer_disc_mask),
		.peer_maxturn_mask(peer_maxturn_mask),
		.peer_datasize_mask(peer_datasize_mask),
		.peer_window_mask(peer_window_mask), .peer_bofs_mask(peer_bofs_mask),
		.peer_minturn_mask(peer_minturn_mask),
		.agreed_baud_mask(agreed_baud_mask), .agreed_disc_mask(agreed_disc_mask),
		.baud_bps(baud_bps), .frame_bytes(frame_bytes),
		.window_frames(window_frames), .extra_bofs(extra_bofs),
		.min_turn_us(min_turn_us), .max_turn_ms(max_turn_ms),
		.disc_seconds(disc_seconds), .status(status)
	);

endmodule
`default_nettype wire

### sim/tb_link_qos_negotiator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_link_qos_negotiator
// Drives random and directed capability mask sets into the link negotiator,
// predicts each agreed parameter set and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_link_qos_negotiator;

	typedef struct {
		logic [15:0] baud;
		logic [7:0]  disc;
		logic [7:0]  maxturn;
		logic [7:0]  dsize;
		logic [7:0]  window;
		logic [7:0]  bofs;
		logic [7:0]  minturn;
	} caps_t;

	typedef struct {
		logic [9:0]  abaud;
		logic [7:0]  adisc;
		logic [23:0] bps;
		logic [11:0] frame;
		logic [3:0]  win;
		logic [5:0]  bofs;
		logic [13:0] mint;
		logic [8:0]  maxt;
		logic [5:0]  dsec;
		lqn_pkg::status_t st;
	} terms_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = lqn_pkg::REG_BAUD;
	logic [9:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [15:0] peer_baud_mask = '0;
	logic [7:0] peer_disc_mask = '0, peer_maxturn_mask = '0, peer_datasize_mask = '0;
	logic [7:0] peer_window_mask = '0, peer_bofs_mask = '0, peer_minturn_mask = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [9:0] agreed_baud_mask;
	logic [7:0] agreed_disc_mask;
	logic [23:0] baud_bps;
	logic [11:0] frame_bytes;
	logic [3:0] window_frames;
	logic [5:0] extra_bofs;
	logic [13:0] min_turn_us;
	logic [8:0] max_turn_ms;
	logic [5:0] disc_seconds;
	logic [1:0] status;

	link_qos_negotiator u_dut (.*);

	always #1 clk = ~clk;

	// Local masks as the block holds them.
	logic [9:0] loc_baud = 10'h3FF;
	logic [7:0] loc_disc = 8'h07;

	caps_t  offer_q[$];
	terms_t agreed_q[$];
	int     mismatches = 0;
	bit     quiet = 1'b0;
	bit     long_hold = 1'b0;

	function automatic int msb_of(input logic [15:0] m);
		int r = -1;
		for (int i = 0; i < 16; i++) if (m[i]) r = i;
		return r;
	endfunction

	// Works out the agreed parameter set for one capability beat.
	function automatic terms_t negotiate(input caps_t c);
		terms_t r;
		int ib, id, it, is, iw, io, im, ti;
		longint unsigned bps, frm, win, bo, mt, capv, req;
		int unsigned bauds[10] = '{2400, 9600, 19200, 38400, 57600, 115200, 576000,
			1152000, 4000000, 16000000};
		int unsigned sizes[6] = '{64, 128, 256, 512, 1024, 2048};
		int unsigned bofv[8] = '{48, 24, 12, 5, 3, 2, 1, 0};
		int unsigned mtv[8] = '{10000, 5000, 1000, 500, 100, 50, 10, 0};
		int unsigned dsv[8] = '{3, 8, 12, 16, 20, 25, 30, 40};
		int unsigned mxv[4] = '{500, 250, 100, 50};
		int unsigned caps[10][4] = '{'{100, 0, 0, 0}, '{400, 0, 0, 0}, '{800, 0, 0, 0},
			'{1600, 0, 0, 0}, '{2360, 0, 0, 0}, '{4800, 2400, 960, 480},
			'{28800, 11520, 5760, 2880}, '{57600, 28800, 11520, 5760},
			'{200000, 100000, 40000, 20000}, '{800000, 400000, 160000, 80000}};
		r = '{st: lqn_pkg::ST_OK, default: '0};
		r.abaud = c.baud[9:0] & loc_baud;
		r.adisc = c.disc & loc_disc;
		ib = msb_of(16'(r.abaud));
		id = msb_of(16'(r.adisc));
		it = msb_of(16'(c.maxturn));
		is = msb_of(16'(c.dsize));
		iw = msb_of(16'(c.window));
		io = msb_of(16'(c.bofs));
		im = msb_of(16'(c.minturn));
		if (ib < 0 || id < 0 || it < 0 || it > 3 || is < 0 || is > 5 || iw < 0 ||
				io < 0 || im < 0) begin
			r.st = lqn_pkg::ST_BADMSK;
			return r;
		end
		bps = bauds[ib];
		frm = sizes[is];
		win = iw + 1;
		bo = bofv[io];
		mt = mtv[im];
		ti = (bps < 115200) ? 0 : it;
		capv = caps[ib][ti];
		forever begin
			req = win * (frm + 6 + bo) + bps * mt / 10000000;
			if (req <= capv) break;
			if (win > 1) win--;
			else if (is > 0) begin
				is--;
				frm = sizes[is];
			end else begin
				r.st = lqn_pkg::ST_NOFIT;
				break;
			end
		end
		r.bps = 24'(bps);
		r.frame = 12'(frm);
		r.win = 4'(win);
		r.bofs = 6'(bo);
		r.mint = 14'(mt);
		r.maxt = 9'(mxv[ti]);
		r.dsec = 6'(dsv[id]);
		return r;
	endfunction

	// Mask with a chosen top bit and random lower bits; top < 0 gives empty.
	function automatic logic [15:0] mask_top(input int top);
		if (top < 0) return '0;
		return (16'd1 << top) | (16'($urandom) & ((16'd1 << top) - 16'd1));
	endfunction

	function automatic caps_t good_caps();
		caps_t c;
		c.baud = mask_top($urandom_range(0, 9)) | ($urandom_range(0, 3) == 0 ?
			16'($urandom) & 16'hFC00 : 16'h0);
		c.disc = 8'(mask_top($urandom_range(0, 7)));
		c.maxturn = 8'(mask_top($urandom_range(0, 3)));
		c.dsize = 8'(mask_top($urandom_range(0, 5)));
		c.window = 8'(mask_top($urandom_range(0, 7)));
		c.bofs = 8'(mask_top($urandom_range(0, 7)));
		c.minturn = 8'(mask_top($urandom_range(0, 7)));
		return c;
	endfunction

	function automatic caps_t noise_caps();
		caps_t c;
		c.baud = 16'($urandom);
		c.disc = 8'($urandom);
		c.maxturn = 8'($urandom);
		c.dsize = 8'($urandom);
		c.window = 8'($urandom);
		c.bofs = 8'($urandom);
		c.minturn = 8'($urandom);
		if ($urandom_range(0, 3) == 0) c.window = '0;
		return c;
	endfunction

	// Acceptance seen at the rising edge, used by the driver on the next fall.
	bit took = 1'b0;
	always @(posedge clk) begin
		took <= in_valid && !in_stall;
	end

	// Driver: offers the next pending beat, with random bursts of idle cycles.
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || took) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_valid <= 1'b0;
				end else if (offer_q.size() > 0) begin
					peer_baud_mask <= offer_q[0].baud;
					peer_disc_mask <= offer_q[0].disc;
					peer_maxturn_mask <= offer_q[0].maxturn;
					peer_datasize_mask <= offer_q[0].dsize;
					peer_window_mask <= offer_q[0].window;
					peer_bofs_mask <= offer_q[0].bofs;
					peer_minturn_mask <= offer_q[0].minturn;
					agreed_q.push_back(negotiate(offer_q[0]));
					offer_q.pop_front();
					in_valid <= 1'b1;
					if (!quiet && $urandom_range(0, 5) == 0)
						send_gap <= $urandom_range(1, 10);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver stall: random bursts, or one long hold-off on request.
	int stall_left = 0;
	int hold_left = 0;
	always @(negedge clk) begin
		if (long_hold && hold_left == 0 && !out_stall) begin
			hold_left <= 200;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1);
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= (stall_left > 1);
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 10);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: compares each result beat with the oldest expectation.
	always @(posedge clk) begin
		terms_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (agreed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat at %0t", $time);
			end else begin
				e = agreed_q.pop_front();
				if (agreed_baud_mask !== e.abaud || agreed_disc_mask !== e.adisc ||
						baud_bps !== e.bps || frame_bytes !== e.frame ||
						window_frames !== e.win || extra_bofs !== e.bofs ||
						min_turn_us !== e.mint || max_turn_ms !== e.maxt ||
						disc_seconds !== e.dsec || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp %h %h %0d %0d %0d %0d %0d %0d %0d %0d", e.abaud,
							e.adisc, e.bps, e.frame, e.win, e.bofs, e.mint, e.maxt, e.dsec, e.st);
						$display("         got %h %h %0d %0d %0d %0d %0d %0d %0d %0d",
							agreed_baud_mask, agreed_disc_mask, baud_bps, frame_bytes,
							window_frames, extra_bofs, min_turn_us, max_turn_ms,
							disc_seconds, status);
					end
				end
			end
		end
	end

	task automatic wait_drained();
		while (offer_q.size() > 0 || in_valid || agreed_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [9:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == lqn_pkg::REG_BAUD) loc_baud = val;
		else loc_disc = val[7:0];
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			offer_q.push_back($urandom_range(0, 4) == 0 ? noise_caps() : good_caps());
	endtask

	// Stimulus sequence.
	initial begin
		caps_t c;
		logic [9:0] baud_set[4] = '{10'h3FF, 10'h001, 10'h020, 10'h000};
		logic [7:0] disc_set[4] = '{8'hFF, 8'h80, 8'h01, 8'h00};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset masks, extremes, each table end, empty and out-of-table.
		c = '{16'hFFFF, 8'hFF, 8'h0F, 8'h3F, 8'hFF, 8'h01, 8'h01};
		offer_q.push_back(c);
		offer_q.push_back('{16'h0001, 8'h01, 8'h01, 8'h01, 8'h01, 8'h80, 8'h80});
		offer_q.push_back('{16'h0001, 8'h01, 8'h08, 8'h20, 8'h80, 8'h01, 8'h01});
		offer_q.push_back('{16'h0010, 8'h04, 8'h08, 8'h20, 8'h80, 8'h80, 8'h80});
		offer_q.push_back('{16'h0020, 8'h02, 8'h08, 8'h20, 8'h80, 8'h01, 8'h01});
		offer_q.push_back('{16'h0200, 8'h04, 8'h08, 8'h20, 8'h80, 8'h01, 8'h01});
		offer_q.push_back('{16'hFC00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01});
		offer_q.push_back('{16'h0001, 8'hF8, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01});
		offer_q.push_back('{16'h0001, 8'h01, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01});
		offer_q.push_back('{16'h0001, 8'h01, 8'h10, 8'h01, 8'h01, 8'h01, 8'h01});
		offer_q.push_back('{16'h0001, 8'h01, 8'h01, 8'h40, 8'h01, 8'h01, 8'h01});
		offer_q.push_back('{16'h0001, 8'h01, 8'h01, 8'h00, 8'h01, 8'h01, 8'h01});
		offer_q.push_back('{16'h0001, 8'h01, 8'h01, 8'h01, 8'h00, 8'h01, 8'h01});
		offer_q.push_back('{16'h0001, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00, 8'h01});
		offer_q.push_back('{16'h0001, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00});
		offer_q.push_back('{16'h0040, 8'h01, 8'h08, 8'h20, 8'h80, 8'h01, 8'h01});
		wait_drained();

		// Random phases over several local mask settings.
		for (int p = 0; p < 5; p++) begin
			write_reg(lqn_pkg::REG_BAUD, p < 4 ? baud_set[p] : 10'($urandom));
			write_reg(lqn_pkg::REG_DISC,
				p < 4 ? 10'(disc_set[p]) : 10'($urandom_range(1, 255)));
			push_random(p == 3 ? 20 : 80);
			wait_drained();
		end

		// Long receiver hold-off while the sender keeps offering.
		write_reg(lqn_pkg::REG_BAUD, 10'h3FF);
		write_reg(lqn_pkg::REG_DISC, 10'h0FF);
		long_hold = 1'b1;
		push_random(60);
		wait (hold_left > 0);
		long_hold = 1'b0;
		wait_drained();

		// Final stretch with no idling.
		quiet = 1'b1;
		push_random(50);
		wait_drained();

		if (mismatches == 0 && agreed_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#400000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
